>>> rtl/bfloat16_arith_unit_defines.svh
// Assertion macros for the bfloat16 arithmetic unit
`ifndef BFLOAT16_ARITH_UNIT_DEFINES_SVH
`define BFLOAT16_ARITH_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define BF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define BF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/bf16_pkg.sv
// Package: operation codes, stage payload types and helper functions
`timescale 1ns / 1ps
package bf16_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [15:0] QNAN     = 16'h7FC0;
  localparam logic [15:0] INF_BITS = 16'h7F80;
  localparam logic [15:0] SIGN_BIT = 16'h8000;
  localparam int          EXP_BIAS = 127;
  localparam logic [7:0]  EXP_ALL  = 8'hFF;
  localparam logic [6:0]  MANT_MASK = 7'h7F;

  // Division quotient width and number of quotient bits per pipeline stage
  localparam int QW        = 16;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = QW / DIV_STEPS;

  // Payload carried down the pipe for one request
  typedef struct packed {
    op_t         op;
    logic        done;     // result already known (special case)
    logic [15:0] res;      // result if done
    logic        rs;
    logic signed [10:0] re;
    logic [7:0]  ma;
    logic [7:0]  mb;
    logic [15:0] wide;     // aligned sum / product / quotient
    logic [16:0] rem;      // divide partial remainder
    logic        sub_neg;  // add: signs differ
  } stage_t;

  // Leading-one position plus one (0 for zero), over 17 bits
  function automatic logic [4:0] bitlen17(input logic [16:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  // Shift needed to bring a 7-bit denormal fraction to hidden-bit form
  function automatic logic [2:0] lz7(input logic [6:0] m);
    logic [2:0] s;
    s = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (m[i]) s = 3'(7 - i);
    end
    return s;
  endfunction

endpackage

>>> rtl/bf16_stage.sv
// One pipeline register stage with valid bit and stall handling
`timescale 1ns / 1ps
module bf16_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             d_valid,
  input  bf16_pkg::stage_t d,
  output logic             q_valid,
  output bf16_pkg::stage_t q
);
  import bf16_pkg::*;

  logic   valid_r;
  stage_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= d;
    end
  end

  assign q_valid = valid_r;
  assign q       = data_r;

endmodule

>>> rtl/bfloat16_arith_unit.sv
// Top level: pipelined bfloat16 add, subtract, multiply and divide
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_ready in_kind in_operand_a/b | request in
//  out     | out_valid out_ready out_result_bits      | result out
//
// One request enters per cycle, unless the output stalls, through seven
// register stages (decode, align/multiply, four divide stages of four
// quotient bits each, normalise/pack).
// The divider's restoring steps set the depth.
// Reset clears only valid bits. A stall at the output holds every stage;
// in_ready is low only while the last stage holds an unaccepted result.
`timescale 1ns / 1ps
module bfloat16_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_bits
);
  import bf16_pkg::*;
  `include "bfloat16_arith_unit_defines.svh"

  localparam int NST = DIV_STAGES + 3;

  logic   adv;
  logic   v   [NST];
  stage_t s   [NST];
  logic   dv  [NST];
  stage_t d   [NST];

  assign adv      = !v[NST-1] || out_ready;
  assign in_ready = adv;

  // ---------------- stage 0: decode and special cases ----------------
  always_comb begin
    stage_t  o;
    logic [15:0] a, b;
    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [6:0]  fa, fb;
    logic        nan_a, nan_b, inf_a, z_a, z_b;
    logic [2:0]  la, lb;
    logic signed [10:0] xa, xb;
    o  = '0;
    a  = in_operand_a;
    b  = (op_t'(in_kind) == OP_SUB) ? (in_operand_b ^ SIGN_BIT) : in_operand_b;
    sa = a[15]; sb = b[15];
    ea = a[14:7]; eb = b[14:7];
    fa = a[6:0];  fb = b[6:0];
    nan_a = (ea == EXP_ALL) && (fa != 7'd0);
    nan_b = (eb == EXP_ALL) && (fb != 7'd0);
    inf_a = (ea == EXP_ALL) && (fa == 7'd0);
    z_a   = (ea == 8'd0) && (fa == 7'd0);
    z_b   = (eb == 8'd0) && (fb == 7'd0);
    la = lz7(fa); lb = lz7(fb);
    o.op = op_t'(in_kind);
    o.rs = sa ^ sb;
    case (o.op) inside
      OP_ADD, OP_SUB: begin
        // add keeps denormals at exponent 1 without hidden bit
        o.ma = (ea != 8'd0) ? {1'b1, fa} : {1'b0, fa};
        o.mb = (eb != 8'd0) ? {1'b1, fb} : {1'b0, fb};
        xa   = (ea != 8'd0) ? 11'(ea) : 11'sd1;
        xb   = (eb != 8'd0) ? 11'(eb) : 11'sd1;
        o.re = xa - xb;          // exponent gap for now
        o.sub_neg = sa ^ sb;
        o.rs = sa;
        // stash exponents in wide for the align stage
        o.wide = {xa[7:0], xb[7:0]};
        if (ea == EXP_ALL) begin
          o.done = 1'b1;
          if (nan_a) o.res = a;
          else if (eb == EXP_ALL) o.res = (nan_b || sa == sb) ? b : QNAN;
          else o.res = a;
        end else if (eb == EXP_ALL) begin
          o.done = 1'b1; o.res = b;
        end else if (z_a) begin
          o.done = 1'b1; o.res = b;
        end else if (z_b) begin
          o.done = 1'b1; o.res = a;
        end else if (o.re > 11'sd8) begin
          o.done = 1'b1; o.res = a;
        end else if (o.re < -11'sd8) begin
          o.done = 1'b1; o.res = b;
        end
      end
      OP_MUL: begin
        o.ma = (ea != 8'd0) ? {1'b1, fa} : 8'({fa, 1'b0} << (la - 3'd1));
        o.mb = (eb != 8'd0) ? {1'b1, fb} : 8'({fb, 1'b0} << (lb - 3'd1));
        xa = (ea != 8'd0) ? 11'(ea) : 11'sd1 - 11'(la);
        xb = (eb != 8'd0) ? 11'(eb) : 11'sd1 - 11'(lb);
        o.re = xa + xb - 11'(EXP_BIAS);
        if (ea == EXP_ALL) begin
          o.done = 1'b1;
          o.res  = fa != 7'd0 ? a : (z_b ? QNAN : ({o.rs, 15'd0} | INF_BITS));
        end else if (eb == EXP_ALL) begin
          o.done = 1'b1;
          o.res  = fb != 7'd0 ? b : (z_a ? QNAN : ({o.rs, 15'd0} | INF_BITS));
        end else if (z_a || z_b) begin
          o.done = 1'b1; o.res = {o.rs, 15'd0};
        end
      end
      default: begin
        o.ma = (ea != 8'd0) ? {1'b1, fa} : 8'({fa, 1'b0} << (la - 3'd1));
        o.mb = (eb != 8'd0) ? {1'b1, fb} : 8'({fb, 1'b0} << (lb - 3'd1));
        xa = (ea != 8'd0) ? 11'(ea) : 11'sd1 - 11'(la);
        xb = (eb != 8'd0) ? 11'(eb) : 11'sd1 - 11'(lb);
        o.re  = xa - xb + 11'(EXP_BIAS);
        o.rem = {1'b0, o.ma, 8'd0};   // dividend ma << 15 handled bitwise
        if (eb == EXP_ALL) begin
          o.done = 1'b1;
          o.res  = nan_b ? b : (inf_a ? QNAN : {o.rs, 15'd0});
        end else if (z_b) begin
          o.done = 1'b1;
          o.res  = z_a ? QNAN : ({o.rs, 15'd0} | INF_BITS);
        end else if (ea == EXP_ALL) begin
          o.done = 1'b1;
          o.res  = nan_a ? a : ({o.rs, 15'd0} | INF_BITS);
        end else if (z_a) begin
          o.done = 1'b1; o.res = {o.rs, 15'd0};
        end
      end
    endcase
    dv[0] = in_valid;
    d[0]  = o;
  end

  // ---------------- stage 1: align and add, or multiply ----------------
  always_comb begin
    stage_t o;
    logic [15:0] am, bm;
    logic [3:0]  gap;
    o = s[0];
    am = {8'd0, s[0].ma};
    bm = {8'd0, s[0].mb};
    case (s[0].op) inside
      OP_ADD, OP_SUB: begin
        if (!s[0].re[10] && s[0].re != 11'sd0) begin
          gap = 4'(s[0].re);
          am  = am << gap;
          o.re = 11'(s[0].wide[7:0]);
        end else begin
          gap = 4'(-s[0].re);
          bm  = bm << gap;
          o.re = 11'(s[0].wide[15:8]);
        end
        if (!s[0].sub_neg) begin
          o.wide = am + bm;
        end else if (am >= bm) begin
          o.wide = am - bm;
        end else begin
          o.wide = bm - am;
          o.rs   = ~s[0].rs;
        end
      end
      OP_MUL: begin
        o.wide = s[0].ma * s[0].mb;
      end
      default: begin
        o.wide = '0;
      end
    endcase
    dv[1] = v[0];
    d[1]  = o;
  end

  // ---------------- stages 2..: restoring divide, four bits each -------
  // Partial remainder r starts as ma; each step r = 2r, subtract mb if fits.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_comb begin
      stage_t o;
      logic [16:0] r;
      logic [15:0] q;
      o = s[g+1];
      r = (g == 0) ? {9'd0, s[g+1].ma} : s[g+1].rem;
      q = (g == 0) ? 16'd0 : s[g+1].wide;
      if (s[g+1].op == OP_DIV && !s[g+1].done) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
          // first quotient bit compares ma itself (ma << 15 >> 15)
          if (!(g == 0 && k == 0)) r = {r[15:0], 1'b0};
          q = {q[14:0], 1'b0};
          if (r >= {9'd0, s[g+1].mb}) begin
            r    = r - {9'd0, s[g+1].mb};
            q[0] = 1'b1;
          end
        end
        o.rem  = r;
        o.wide = q;
      end
      dv[g+2] = v[g+1];
      d[g+2]  = o;
    end
  end

  // ---------------- last stage: normalise and pack ----------------
  always_comb begin
    stage_t      o;
    stage_t      t;
    logic [4:0]  n;
    logic [4:0]  sh;
    logic [16:0] rm;
    logic signed [10:0] re;
    logic [7:0]  m;
    o  = s[NST-2];
    t  = s[NST-2];
    rm = {1'b0, t.wide};
    re = t.re;
    n  = bitlen17(rm);
    sh = 5'd0;
    m  = 8'd0;
    if (!t.done) begin
      o.done = 1'b1;
      case (t.op) inside
        OP_ADD, OP_SUB: begin
          if (rm == 17'd0) begin
            o.res = 16'd0;
          end else if (!t.sub_neg && n < 5'd8) begin
            o.res = {t.rs, 8'd0, rm[6:0]};
          end else if (n < 5'd8) begin
            sh = 5'd8 - n;
            if (re - $signed(11'(sh)) <= 11'sd0) o.res = 16'd0;
            else begin
              rm = rm << sh;
              re = re - $signed(11'(sh));
              o.res = {t.rs, re[7:0], rm[6:0]};
            end
          end else begin
            sh = n - 5'd8;
            if (re + $signed(11'(sh)) >= 11'sd255) o.res = QNAN;
            else begin
              rm = rm >> sh;
              re = re + $signed(11'(sh));
              o.res = {t.rs, re[7:0], rm[6:0]};
            end
          end
        end
        OP_MUL: begin
          if (t.wide[15]) begin
            m  = t.wide[15:8];
            re = re + 11'sd1;
          end else begin
            m  = t.wide[14:7];
          end
          if (re >= 11'sd255) o.res = {t.rs, 15'd0} | INF_BITS;
          else if (re < -11'sd6) o.res = {t.rs, 15'd0};
          else if (re <= 11'sd0) begin
            m = m >> (3'(11'sd1 - re));
            o.res = {t.rs, 8'd0, m[6:0]};
          end else o.res = {t.rs, re[7:0], m[6:0]};
        end
        default: begin
          rm = {1'b0, t.wide};
          if (!t.wide[15]) begin
            rm = rm << 1;
            re = re - 11'sd1;
          end
          if (re >= 11'sd255) o.res = {t.rs, 15'd0} | INF_BITS;
          else if (re <= 11'sd0) o.res = {t.rs, 15'd0};
          else o.res = {t.rs, re[7:0], rm[14:8]};
        end
      endcase
    end
    dv[NST-1] = v[NST-2];
    d[NST-1]  = o;
  end

  for (genvar g = 0; g < NST; g++) begin : g_pipe
    bf16_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .d_valid (dv[g]),
      .d       (d[g]),
      .q_valid (v[g]),
      .q       (s[g])
    );
  end

  assign out_valid       = v[NST-1];
  assign out_result_bits = s[NST-1].res;

  // Last stage holds its result while stalled
  `BF_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_result_bits), "result lost in stall")
  // Anything reaching the output has been resolved
  `BF_ASSERT(a_done, out_valid |-> s[NST-1].done, "unresolved result at output")
  // Input side stalls only behind a blocked result
  `BF_ASSERT(a_ready, in_ready == (!out_valid || out_ready), "input ready out of step")
  // Reset empties the pipe
  `BF_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "output valid after reset")

endmodule
